// File: hdl/bucket_classifier_histogram_defines.svh
// Assertion macros shared by the histogram RTL.
`ifndef BUCKET_CLASSIFIER_HISTOGRAM_DEFINES_SVH
`define BUCKET_CLASSIFIER_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCH_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BCH_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bch_pkg.sv
`default_nettype none
package bch_pkg;

  localparam int MAX_BUCKETS = 256;
  localparam int VALUE_W     = 64;
  localparam int IDX_W       = $clog2(MAX_BUCKETS);
  localparam int BC_W        = IDX_W + 1;
  localparam int CNT_W       = 32;
  localparam int CMD_W       = 2;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = BC_W;

  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_COMPARE = CFG_IDX_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD     = 2'd0,
    CMD_CLASSIFY = 2'd1,
    CMD_READ     = 2'd2
  } cmd_t;

  // Table read address source.
  typedef enum logic [1:0] {
    AS_SEARCH,
    AS_LAST,
    AS_IDX
  } addr_sel_t;

  typedef struct packed {
    logic      latch;
    logic      step;
    addr_sel_t addr_sel;
    logic      load_wr;
    logic      update;
    logic      max_wr;
    logic      cap_read;
    logic      cap_none;
  } dp_cmd_t;

  typedef struct packed {
    logic search_more;
    logic need_max;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: hdl/bch_ram.sv
`default_nettype none
module bch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/bch_ctrl.sv
`default_nettype none
`include "bucket_classifier_histogram_defines.svh"
module bch_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [bch_pkg::CMD_W-1:0] in_cmd,
  output logic                           busy,
  output logic                           out_valid,
  output bch_pkg::dp_cmd_t               dp_cmd,
  input  wire bch_pkg::dp_stat_t         dp_stat
);
  import bch_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ISSUE,
    S_CMP,
    S_UPDATE,
    S_MAX,
    S_LOAD,
    S_READ,
    S_READ_D,
    S_NONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = 1'b0;
    dp_cmd          = '0;
    dp_cmd.addr_sel = AS_IDX;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          dp_cmd.latch = 1'b1;
          case (cmd_t'(in_cmd))
            CMD_LOAD:     state_nxt = S_LOAD;
            CMD_CLASSIFY: state_nxt = S_ISSUE;
            CMD_READ:     state_nxt = S_READ;
            default:      state_nxt = S_NONE;
          endcase
        end
      end
      S_ISSUE: begin
        dp_cmd.addr_sel = AS_SEARCH;
        state_nxt       = dp_stat.search_more ? S_CMP : S_UPDATE;
      end
      S_CMP: begin
        dp_cmd.step     = 1'b1;
        dp_cmd.addr_sel = AS_SEARCH;
        state_nxt       = dp_stat.search_more ? S_CMP : S_UPDATE;
      end
      S_UPDATE: begin
        dp_cmd.update   = 1'b1;
        dp_cmd.addr_sel = AS_LAST;
        if (dp_stat.need_max) begin
          state_nxt = S_MAX;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_MAX: begin
        dp_cmd.max_wr = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_LOAD: begin
        dp_cmd.load_wr = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_READ: begin
        state_nxt = S_READ_D;
      end
      S_READ_D: begin
        dp_cmd.cap_read = 1'b1;
        out_valid_nxt   = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_NONE: begin
        dp_cmd.cap_none = 1'b1;
        out_valid_nxt   = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `BCH_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted item not busy")
  `BCH_ASSERT_SAME(a_strobe_idle, clk, rst_n, out_valid_r, state_r == S_IDLE, "strobe while busy")
  `BCH_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid_r, !out_valid_r, "strobe repeated")

endmodule
`default_nettype wire

// File: hdl/bch_datapath.sv
`default_nettype none
`include "bucket_classifier_histogram_defines.svh"
module bch_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire bch_pkg::dp_cmd_t               dp_cmd,
  output bch_pkg::dp_stat_t                   dp_stat,
  input  wire logic [bch_pkg::IDX_W-1:0]      in_entry_index,
  input  wire logic [bch_pkg::VALUE_W-1:0]    in_sample_value,
  input  wire logic                           cfg_we,
  input  wire logic [bch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bch_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic      [bch_pkg::IDX_W-1:0]      out_bucket,
  output logic                                out_exact_match,
  output logic      [bch_pkg::VALUE_W-1:0]    out_entry_bound,
  output logic      [bch_pkg::CNT_W-1:0]      out_entry_count,
  output logic                                out_entry_multi
);
  import bch_pkg::*;

  function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] x,
                                                   input logic sgn);
    return {x[VALUE_W-1] ^ sgn, x[VALUE_W-2:0]};
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + CNT_W'(1);
  endfunction

  // Configuration
  logic [IDX_W-1:0] last_r, last_nxt;
  logic             signed_r, signed_nxt;
  logic [BC_W-1:0]  bc_clamped;

  // Item and search state
  logic [IDX_W-1:0]   idx_r;
  logic [VALUE_W-1:0] val_r;
  logic [IDX_W-1:0]   base_r, base_nxt;
  logic [IDX_W-1:0]   rem_r, rem_nxt;
  logic [IDX_W-1:0]   half, probe, search_addr;
  logic [VALUE_W-1:0] key_v, key_b;
  logic               search_more, need_max;

  // Histogram state
  logic [MAX_BUCKETS-1:0] valid_r, valid_nxt;
  logic                   valid_rd_r;
  logic [CNT_W-1:0]       total_r, total_nxt;

  // Tables
  logic [IDX_W-1:0]   rd_addr;
  logic               bram_we;
  logic [IDX_W-1:0]   bram_waddr;
  logic [VALUE_W-1:0] bnd_rd;
  logic [CNT_W:0]     cram_rd, cram_wdata;

  logic             exact, lower0, raise;
  logic [CNT_W-1:0] cnt_eff, cnt_new;
  logic             multi_eff, multi_new;

  // Result registers
  logic [IDX_W-1:0]   bucket_r, bucket_nxt;
  logic               exact_r, exact_nxt;
  logic [VALUE_W-1:0] bound_r, bound_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               multi_r, multi_nxt;

  always_comb begin
    if (cfg_wdata < BC_W'(2)) begin
      bc_clamped = BC_W'(2);
    end else if (cfg_wdata > BC_W'(MAX_BUCKETS)) begin
      bc_clamped = BC_W'(MAX_BUCKETS);
    end else begin
      bc_clamped = cfg_wdata;
    end
    last_nxt   = last_r;
    signed_nxt = signed_r;
    if (cfg_we && cfg_index == REG_BUCKET_COUNT) begin
      last_nxt = IDX_W'(bc_clamped - BC_W'(1));
    end
    if (cfg_we && cfg_index == REG_SIGNED_COMPARE) begin
      signed_nxt = cfg_wdata[0];
    end
  end

  assign key_v = order_key(val_r, signed_r);
  assign key_b = order_key(bnd_rd, signed_r);

  // Search step: halve the remaining span, keep the upper half on a hit.
  always_comb begin
    half     = {1'b0, rem_r[IDX_W-1:1]};
    probe    = base_r + half;
    base_nxt = base_r;
    rem_nxt  = rem_r;
    if (dp_cmd.step) begin
      base_nxt = (key_b <= key_v) ? probe : base_r;
      rem_nxt  = rem_r - half;
    end
    search_more = (rem_nxt > IDX_W'(1));
    search_addr = search_more ? base_nxt + {1'b0, rem_nxt[IDX_W-1:1]} : base_nxt;
  end

  always_comb begin
    case (dp_cmd.addr_sel)
      AS_SEARCH: rd_addr = search_addr;
      AS_LAST:   rd_addr = last_r;
      AS_IDX:    rd_addr = idx_r;
      default:   rd_addr = idx_r;
    endcase
  end

  always_comb begin
    cnt_eff   = valid_rd_r ? cram_rd[CNT_W-1:0] : '0;
    multi_eff = valid_rd_r & cram_rd[CNT_W];
    exact     = (bnd_rd == val_r);
    lower0    = !exact && (base_r == '0) && (key_v < key_b);
    raise     = key_v > key_b;
    cnt_new   = sat_inc(cnt_eff);
    multi_new = multi_eff | !exact;
    cram_wdata = {multi_new, cnt_new};
    need_max  = !exact && (base_r == last_r - IDX_W'(1));

    bram_we    = dp_cmd.load_wr | (dp_cmd.update & lower0) | (dp_cmd.max_wr & raise);
    bram_waddr = dp_cmd.load_wr ? idx_r : (dp_cmd.update ? '0 : last_r);

    valid_nxt = valid_r;
    total_nxt = total_r;
    if (dp_cmd.load_wr) begin
      valid_nxt[idx_r] = 1'b0;
    end
    if (dp_cmd.update) begin
      valid_nxt[base_r] = 1'b1;
      total_nxt         = sat_inc(total_r);
    end
  end

  assign dp_stat = '{search_more: search_more, need_max: need_max};

  always_comb begin
    bucket_nxt = bucket_r;
    exact_nxt  = exact_r;
    bound_nxt  = bound_r;
    count_nxt  = count_r;
    multi_nxt  = multi_r;
    if (dp_cmd.load_wr) begin
      bucket_nxt = idx_r;
      exact_nxt  = 1'b0;
      bound_nxt  = val_r;
      count_nxt  = '0;
      multi_nxt  = 1'b0;
    end else if (dp_cmd.update) begin
      bucket_nxt = base_r;
      exact_nxt  = exact;
      bound_nxt  = lower0 ? val_r : bnd_rd;
      count_nxt  = cnt_new;
      multi_nxt  = multi_new;
    end else if (dp_cmd.cap_read) begin
      bucket_nxt = idx_r;
      exact_nxt  = 1'b0;
      bound_nxt  = bnd_rd;
      count_nxt  = (idx_r == last_r) ? total_r : cnt_eff;
      multi_nxt  = multi_eff;
    end else if (dp_cmd.cap_none) begin
      bucket_nxt = idx_r;
      exact_nxt  = 1'b0;
      bound_nxt  = '0;
      count_nxt  = '0;
      multi_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= IDX_W'(MAX_BUCKETS - 1);
      signed_r <= 1'b0;
      valid_r  <= '0;
      total_r  <= '0;
    end else begin
      last_r   <= last_nxt;
      signed_r <= signed_nxt;
      valid_r  <= valid_nxt;
      total_r  <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.latch) begin
      idx_r  <= in_entry_index;
      val_r  <= in_sample_value;
      base_r <= '0;
      rem_r  <= last_r;
    end else begin
      base_r <= base_nxt;
      rem_r  <= rem_nxt;
    end
    valid_rd_r <= valid_r[rd_addr];
    bucket_r   <= bucket_nxt;
    exact_r    <= exact_nxt;
    bound_r    <= bound_nxt;
    count_r    <= count_nxt;
    multi_r    <= multi_nxt;
  end

  bch_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(MAX_BUCKETS)
  ) u_bound_ram (
    .clk  (clk),
    .we   (bram_we),
    .waddr(bram_waddr),
    .wdata(val_r),
    .raddr(rd_addr),
    .rdata(bnd_rd)
  );

  bch_ram #(
    .WIDTH(CNT_W + 1),
    .DEPTH(MAX_BUCKETS)
  ) u_count_ram (
    .clk  (clk),
    .we   (dp_cmd.update),
    .waddr(base_r),
    .wdata(cram_wdata),
    .raddr(rd_addr),
    .rdata(cram_rd)
  );

  assign out_bucket      = bucket_r;
  assign out_exact_match = exact_r;
  assign out_entry_bound = bound_r;
  assign out_entry_count = count_r;
  assign out_entry_multi = multi_r;

  `BCH_ASSERT_SAME(a_probe_span, clk, rst_n, dp_cmd.step, rem_r > IDX_W'(1), "probe on empty span")

endmodule
`default_nettype wire

// File: hdl/bucket_classifier_histogram.sv
// A load writes one bound entry; a read reads the tables, then captures the entry;
//   a classify searches the bounds and updates the hit bucket, then may widen the max
//   when the top bucket is hit. Items are handled one at a time; start is taken again in
//   the out_valid cycle, and the search does one bound-table read per search step.
// Reset (rst_n low, synchronous): counts, flags, total and config return to defaults;
//   bounds hold garbage until loaded. Results cannot be stalled by the receiver.
`default_nettype none
module bucket_classifier_histogram (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Item channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [bch_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [bch_pkg::IDX_W-1:0]      in_entry_index,
  input  wire logic [bch_pkg::VALUE_W-1:0]    in_sample_value,
  // Result channel, one-cycle strobe
  output logic                                out_valid,
  output logic      [bch_pkg::IDX_W-1:0]      out_bucket,
  output logic                                out_exact_match,
  output logic      [bch_pkg::VALUE_W-1:0]    out_entry_bound,
  output logic      [bch_pkg::CNT_W-1:0]      out_entry_count,
  output logic                                out_entry_multi,
  // Configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bch_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bch_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     cfg_we;

  // Registers are plain flops; take a write on every cycle it is offered.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  // Controller: latch, then for a classify search steps, update, optional max widen.
  bch_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_cmd   (in_cmd),
    .busy     (busy),
    .out_valid(out_valid),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat)
  );

  // Datapath holds the bound and count tables, the search registers and the result.
  bch_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .dp_cmd         (dp_cmd),
    .dp_stat        (dp_stat),
    .in_entry_index (in_entry_index),
    .in_sample_value(in_sample_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_bucket     (out_bucket),
    .out_exact_match(out_exact_match),
    .out_entry_bound(out_entry_bound),
    .out_entry_count(out_entry_count),
    .out_entry_multi(out_entry_multi)
  );

endmodule
`default_nettype wire

// File: tb/histogram_checker.sv
`default_nettype none
module histogram_checker
  import bch_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire logic [CMD_W-1:0]      in_cmd,
  input  wire logic [IDX_W-1:0]      in_entry_index,
  input  wire logic [VALUE_W-1:0]    in_sample_value,
  input  wire logic                  out_valid,
  input  wire logic [IDX_W-1:0]      out_bucket,
  input  wire logic                  out_exact_match,
  input  wire logic [VALUE_W-1:0]    out_entry_bound,
  input  wire logic [CNT_W-1:0]      out_entry_count,
  input  wire logic                  out_entry_multi,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                         mismatch_count,
  output int                         results_due
);

  typedef struct packed {
    logic [IDX_W-1:0]   bucket;
    logic               exact;
    logic [VALUE_W-1:0] bound;
    logic [CNT_W-1:0]   count;
    logic               multi;
  } hist_result_t;

  localparam logic [VALUE_W-1:0] SIGN_BIT   = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [CNT_W-1:0]   COUNT_CEIL = '1;

  logic [VALUE_W-1:0]  bound_tab [MAX_BUCKETS];
  logic [CNT_W-1:0]    count_tab [MAX_BUCKETS];
  logic                multi_tab [MAX_BUCKETS];
  logic [CNT_W-1:0]    total_seen;
  logic [CFG_DATA_W-1:0] bucket_cfg;
  logic                signed_mode;
  hist_result_t        due_results [$];
  int                  mismatches_seen;

  // Flip the sign bit so an unsigned compare orders two's complement values.
  function automatic logic [VALUE_W-1:0] order_of(input logic [VALUE_W-1:0] v);
    return signed_mode ? (v ^ SIGN_BIT) : v;
  endfunction

  function automatic int buckets_active();
    if (bucket_cfg < 2) return 2;
    if (bucket_cfg > MAX_BUCKETS) return MAX_BUCKETS;
    return int'(bucket_cfg);
  endfunction

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == COUNT_CEIL) ? c : c + 1'b1;
  endfunction

  task automatic apply_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                            input logic [VALUE_W-1:0] v, output hist_result_t r);
    int n, base, span, half;
    logic [VALUE_W-1:0] key;
    n = buckets_active();
    key = order_of(v);
    r = '0;
    r.bucket = idx;
    case (cmd)
      CMD_LOAD: begin
        bound_tab[idx] = v;
        count_tab[idx] = '0;
        multi_tab[idx] = 1'b0;
        r.bound = v;
      end
      CMD_CLASSIFY: begin
        base = 0;
        span = n - 1;
        while (span > 1) begin
          half = span >> 1;
          if (order_of(bound_tab[base + half]) <= key) base += half;
          span -= half;
        end
        r.exact = (bound_tab[base] == v);
        // widen the observed range on a miss at either end
        if (!r.exact) begin
          if (base == 0 && key < order_of(bound_tab[0])) bound_tab[0] = v;
          if (base == n - 2 && key > order_of(bound_tab[n - 1])) bound_tab[n - 1] = v;
          multi_tab[base] = 1'b1;
        end
        count_tab[base] = bump(count_tab[base]);
        total_seen = bump(total_seen);
        r.bucket = base[IDX_W-1:0];
        r.bound = bound_tab[base];
        r.count = count_tab[base];
        r.multi = multi_tab[base];
      end
      CMD_READ: begin
        r.bound = bound_tab[idx];
        r.count = (idx == n - 1) ? total_seen : count_tab[idx];
        r.multi = multi_tab[idx];
      end
      default: ;
    endcase
  endtask

  task automatic note_miss(input string what, input hist_result_t want, input hist_result_t got);
    mismatches_seen++;
    if (mismatches_seen <= 10) begin
      $display("%s: expected bucket=%0d exact=%0b bound=%h count=%0d multi=%0b",
               what, want.bucket, want.exact, want.bound, want.count, want.multi);
      $display("  got bucket=%0d exact=%0b bound=%h count=%0d multi=%0b",
               got.bucket, got.exact, got.bound, got.count, got.multi);
    end
  endtask

  always @(posedge clk) begin : watch
    hist_result_t want, got;
    if (!rst_n) begin
      for (int i = 0; i < MAX_BUCKETS; i++) begin
        bound_tab[i] = '0;
        count_tab[i] = '0;
        multi_tab[i] = 1'b0;
      end
      total_seen = '0;
      bucket_cfg = CFG_DATA_W'(MAX_BUCKETS);
      signed_mode = 1'b0;
      due_results.delete();
      mismatches_seen = 0;
    end else begin
      // retire the result first: it belongs to an item accepted earlier
      if (out_valid) begin
        got = {out_bucket, out_exact_match, out_entry_bound, out_entry_count, out_entry_multi};
        if (due_results.size() == 0) begin
          note_miss("unexpected result", '0, got);
        end else begin
          want = due_results.pop_front();
          if (want != got) note_miss("result mismatch", want, got);
        end
      end
      if (start && !busy) begin
        apply_item(in_cmd, in_entry_index, in_sample_value, want);
        due_results.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BUCKET_COUNT) bucket_cfg = cfg_wdata;
        else if (cfg_index == REG_SIGNED_COMPARE) signed_mode = cfg_wdata[0];
      end
    end
    mismatch_count <= mismatches_seen;
    results_due <= due_results.size();
  end

endmodule
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
  import bch_pkg::*;

  // Spare command code: the block must change nothing and echo the index.
  localparam logic [CMD_W-1:0]   CMD_UNUSED  = 2'd3;
  localparam logic [VALUE_W-1:0] SIGN_BIT    = {1'b1, {(VALUE_W-1){1'b0}}};
  // Slowest run is roughly 1600 items, each with its busy time and any idle gaps in front.
  localparam int                 CYCLE_LIMIT = 600000;
  localparam int                 PHASES      = 10;
  localparam int                 PHASE_ITEMS = 43;

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  start           = 1'b0;
  logic                  busy;
  logic [CMD_W-1:0]      in_cmd          = '0;
  logic [IDX_W-1:0]      in_entry_index  = '0;
  logic [VALUE_W-1:0]    in_sample_value = '0;
  logic                  out_valid;
  logic [IDX_W-1:0]      out_bucket;
  logic                  out_exact_match;
  logic [VALUE_W-1:0]    out_entry_bound;
  logic [CNT_W-1:0]      out_entry_count;
  logic                  out_entry_multi;
  logic                  cfg_valid       = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata       = '0;

  int mismatch_count;
  int results_due;
  int cycle_count = 0;

  // Mirror of what the sender has loaded: reads and classifies only ever touch
  // entries that hold a written bound, since unwritten bounds are garbage.
  bit                 loaded_tab [MAX_BUCKETS];
  logic [VALUE_W-1:0] bound_copy [MAX_BUCKETS];
  int                 cur_n      = 2;
  bit                 cur_signed = 1'b0;
  bit                 gaps_on    = 1'b1;

  // Per-phase settings: extremes of the bucket count, out-of-range codes that
  // clamp to 2 or to the table size, and both compare modes.
  int phase_bc [PHASES] = '{2, 0, 17, 256, 300, 511, 1, 3, 100, 255};
  bit phase_sg [PHASES] = '{1, 0, 1, 0, 1, 0, 0, 1, 0, 1};

  bucket_classifier_histogram dut (.*);
  histogram_checker checker_i (.*);

  always #2 clk = ~clk;

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [VALUE_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic int clamp_count(input int bc);
    if (bc < 2) return 2;
    if (bc > MAX_BUCKETS) return MAX_BUCKETS;
    return bc;
  endfunction

  // Sample values cluster on and around loaded bounds so exact hits, misses
  // just past a bound and misses at either end of the range all show up.
  function automatic logic [VALUE_W-1:0] pick_sample();
    logic [VALUE_W-1:0] near;
    near = bound_copy[$urandom_range(cur_n - 1)];
    case ($urandom_range(9))
      0, 1:    return rand_word();
      2, 3, 4: return near;
      5, 6:    return near + VALUE_W'($urandom_range(1, 1000));
      7:       return near - VALUE_W'($urandom_range(1, 1000));
      8: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return '1;
          2:       return SIGN_BIT;
          default: return ~SIGN_BIT;
        endcase
      end
      default: return rand_word() >> $urandom_range(1, 63);
    endcase
  endfunction

  // Present one item and hold it until the block takes it. Idle cycles go in
  // front, one at a time, each one an edge at which the block is free but start
  // is low; start drops while the previous item is still in flight.
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx,
                           input logic [VALUE_W-1:0] v);
    while (gaps_on && $urandom_range(99) < 38) begin
      start <= 1'b0;
      do @(posedge clk); while (busy);
    end
    start           <= 1'b1;
    in_cmd          <= c;
    in_entry_index  <= idx;
    in_sample_value <= v;
    do @(posedge clk); while (busy);
    if (c == CMD_LOAD) begin
      loaded_tab[idx] = 1'b1;
      bound_copy[idx] = v;
    end
  endtask

  // Drop start and hold until every expected result has come back. The first
  // edge lets results_due count the item accepted at the current edge.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input logic [CFG_DATA_W-1:0] d);
    if (gaps_on && $urandom_range(99) < 38) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Only call with the block idle. Upper bits of the compare-mode word are
  // random: only bit 0 counts.
  task automatic configure(input int bc, input bit sg);
    write_reg(REG_BUCKET_COUNT, CFG_DATA_W'(bc));
    write_reg(REG_SIGNED_COMPARE, {(CFG_DATA_W-1)'($urandom), sg});
    cfg_valid  <= 1'b0;
    cur_n      = clamp_count(bc);
    cur_signed = sg;
  endtask

  // Fill entries 0..n-1. Sorted tables step upward in compare order with a
  // random spread; the unsorted one is plain noise.
  task automatic load_table(input int n, input bit sorted);
    logic [VALUE_W-1:0] key;
    int shift;
    case ($urandom_range(3))
      0:       shift = 9;
      1:       shift = 24;
      2:       shift = 44;
      default: shift = 58;
    endcase
    key = VALUE_W'($urandom) << $urandom_range(0, 30);
    for (int i = 0; i < n; i++) begin
      if (sorted) send_item(CMD_LOAD, IDX_W'(i), cur_signed ? (key ^ SIGN_BIT) : key);
      else send_item(CMD_LOAD, IDX_W'(i), rand_word());
      key = key + 1 + (rand_word() >> shift);
    end
  endtask

  task automatic random_item();
    int r, idx;
    r = $urandom_range(99);
    if (r < 58) begin
      send_item(CMD_CLASSIFY, IDX_W'($urandom), pick_sample());
    end else if (r < 78) begin
      idx = $urandom_range(MAX_BUCKETS - 1);
      if (!loaded_tab[idx]) idx = $urandom_range(cur_n - 1);
      send_item(CMD_READ, IDX_W'(idx), rand_word());
    end else if (r < 92) begin
      // reloads clear counts; reloading the same bound keeps the table sorted
      idx = $urandom_range(MAX_BUCKETS - 1);
      if (idx < cur_n && $urandom_range(1)) send_item(CMD_LOAD, IDX_W'(idx), bound_copy[idx]);
      else send_item(CMD_LOAD, IDX_W'(idx), $urandom_range(1) ? pick_sample() : rand_word());
    end else begin
      send_item(CMD_UNUSED, IDX_W'($urandom), rand_word());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: four buckets, unsigned compare.
    configure(4, 1'b0);
    send_item(CMD_UNUSED, '1, '1);
    send_item(CMD_LOAD, 8'd0, 64'd100);
    send_item(CMD_LOAD, 8'd1, 64'd200);
    send_item(CMD_LOAD, 8'd2, 64'd300);
    send_item(CMD_LOAD, 8'd3, 64'd400);
    send_item(CMD_LOAD, '1, '1);              // top table entry, all-ones bound
    send_item(CMD_READ, '1, '0);
    send_item(CMD_CLASSIFY, '0, 64'd100);     // exact hit in bucket 0
    send_item(CMD_CLASSIFY, '0, 64'd50);      // below all bounds: lowers bound 0
    send_item(CMD_CLASSIFY, '0, 64'd250);     // miss inside bucket 1
    send_item(CMD_CLASSIFY, '0, '0);          // smallest value
    send_item(CMD_CLASSIFY, '0, '1);          // above the max: raises it
    send_item(CMD_CLASSIFY, '0, 64'd300);     // exact hit in the last searched bucket
    send_item(CMD_READ, 8'd0, '0);
    send_item(CMD_READ, 8'd3, '0);            // last entry reports the total
    send_item(CMD_READ, 8'd1, '0);
    send_item(CMD_LOAD, 8'd0, '0);            // reload clears count and flag
    send_item(CMD_READ, 8'd0, '0);

    // Directed: same table, signed compare; the extreme signed values widen
    // both ends.
    wait_idle();
    configure(4, 1'b1);
    send_item(CMD_LOAD, 8'd3, 64'd400);
    send_item(CMD_CLASSIFY, '0, SIGN_BIT);
    send_item(CMD_CLASSIFY, '0, ~SIGN_BIT);
    send_item(CMD_READ, 8'd3, '0);

    // Random phases, each with a fresh setting and a freshly loaded table.
    // One phase runs with no idle cycles at all, one with an unsorted table.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      gaps_on = (p != 3);
      configure(phase_bc[p], phase_sg[p]);
      load_table(cur_n, p != 5);
      repeat (PHASE_ITEMS) random_item();
    end

    wait_idle();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
+incdir+hdl
hdl/bch_pkg.sv
hdl/bch_ram.sv
hdl/bch_ctrl.sv
hdl/bch_datapath.sv
hdl/bucket_classifier_histogram.sv
tb/histogram_checker.sv
tb/testbench.sv
